// ===== sv/ppa_pkg.sv =====
// Shared constants for the per-CPU page allocator.
package ppa_pkg;

  localparam int unsigned ADDR_W = 56;
  localparam int unsigned CPU_ID_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned NUM_CPUS_DEF = 8;
  localparam int unsigned NUM_PAGES_DEF = 32768;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_TOP = 1'd1;

  localparam logic [ADDR_W-1:0] POOL_LOW_RST = 56'd0;
  localparam logic [ADDR_W-1:0] POOL_TOP_RST = 56'd134217728;

endpackage

// ===== sv/ppa_head_store.sv =====
// List head store: head page memory per CPU plus per-CPU non-empty flags.
module ppa_head_store import ppa_pkg::*; #(
  parameter int unsigned NUM_CPUS = NUM_CPUS_DEF,
  parameter int unsigned CPU_W = 3,
  parameter int unsigned PN_W = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [CPU_W-1:0]    rd_cpu_i,
  output logic [PN_W-1:0]     rd_page_o,
  input  logic                wr_en_i,
  input  logic [CPU_W-1:0]    wr_cpu_i,
  input  logic [PN_W-1:0]     wr_page_i,
  input  logic                wr_valid_i,
  output logic [NUM_CPUS-1:0] valid_o
);

  logic [PN_W-1:0]     head_mem [NUM_CPUS];
  logic [PN_W-1:0]     rd_page_q;
  logic [NUM_CPUS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      head_mem[wr_cpu_i] <= wr_page_i;
    end
    if (rd_en_i) begin
      rd_page_q <= head_mem[rd_cpu_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_cpu_i] <= wr_valid_i;
    end
  end

  assign rd_page_o = rd_page_q;
  assign valid_o   = valid_q;

endmodule

// ===== sv/ppa_link_store.sv =====
// Next-link memory indexed by page number; each word is {valid, next page}.
module ppa_link_store import ppa_pkg::*; #(
  parameter int unsigned NUM_PAGES = NUM_PAGES_DEF,
  parameter int unsigned PN_W = 15
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [PN_W-1:0] rd_addr_i,
  output logic [PN_W:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [PN_W-1:0] wr_addr_i,
  input  logic [PN_W:0] wr_data_i
);

  logic [PN_W:0] link_mem [NUM_PAGES];
  logic [PN_W:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      link_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= link_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/per_cpu_page_allocator.sv =====
// Per-CPU LIFO free-list page allocator, top level.
// out_valid_o rises once the head read step (S_HEAD) ends for a free, a bad free or an allocate
// that finds every list empty; an allocate that pops goes on through the link read (S_LINK) first.
// A new word is accepted only back in S_IDLE, so none is taken while one is in flight; a held
// result word stalls input. Reset empties all lists at once (per-CPU flags); no link clear.
module per_cpu_page_allocator import ppa_pkg::*; #(
  parameter int unsigned NUM_CPUS = NUM_CPUS_DEF,
  parameter int unsigned NUM_PAGES = NUM_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [CPU_ID_W-1:0]  cpu_id_i,
  input  logic [ADDR_W-1:0]    page_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ADDR_W-1:0]    result_addr_o,
  output logic [STATUS_W-1:0]  status_o
);

  localparam int unsigned CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned PN_W = $clog2(NUM_PAGES);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;

  function automatic logic [CPU_W-1:0] cpu_wrap(input logic [CPU_ID_W-1:0] id);
    logic [6:0] v;
    v = 7'(id);
    for (int k = 0; k < 8; k++) begin
      if (v >= 7'(NUM_CPUS)) v = v - 7'(NUM_CPUS);
    end
    return v[CPU_W-1:0];
  endfunction

  logic [ADDR_W-1:0] pool_low_q, pool_top_q;
  logic [1:0]        state_q, state_d;
  logic              op_q;
  logic [CPU_W-1:0]  cpu_q, tgt_q;
  logic              found_q, bad_q;
  logic [PN_W-1:0]   pn_q, page_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [STATUS_W-1:0] out_status_q;

  logic              accept;
  logic [CPU_W-1:0]  cpu_m, tgt;
  logic              found, bad;

  logic                head_rd_en, head_wr_en, head_wr_valid;
  logic [CPU_W-1:0]    head_rd_cpu, head_wr_cpu;
  logic [PN_W-1:0]     head_rd_page, head_wr_page;
  logic [NUM_CPUS-1:0] head_valid;

  logic            link_rd_en, link_wr_en;
  logic [PN_W:0]   link_rd_data, link_wr_data;

  logic                done;
  logic [ADDR_W-1:0]   done_addr;
  logic [STATUS_W-1:0] done_status;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_low_q <= POOL_LOW_RST;
      pool_top_q <= POOL_TOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POOL_LOW: pool_low_q <= cfg_data_i;
        CFG_POOL_TOP: pool_top_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // accept only into an empty (or draining) output word
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // own list first, then round-robin from cpu+1
  always_comb begin
    logic [6:0] idx;
    cpu_m = cpu_wrap(cpu_id_i);
    tgt   = cpu_m;
    found = 1'b0;
    for (int i = 0; i < NUM_CPUS; i++) begin
      idx = 7'(cpu_m) + 7'(i);
      if (idx >= 7'(NUM_CPUS)) idx = idx - 7'(NUM_CPUS);
      if (!found && head_valid[idx[CPU_W-1:0]]) begin
        found = 1'b1;
        tgt   = idx[CPU_W-1:0];
      end
    end
  end

  assign bad = (|page_addr_i[PAGE_SHIFT-1:0]) || (page_addr_i < pool_low_q) ||
               (page_addr_i >= pool_top_q) ||
               ((page_addr_i >> PAGE_SHIFT) >= ADDR_W'(NUM_PAGES));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      cpu_q   <= cpu_m;
      tgt_q   <= tgt;
      found_q <= found;
      bad_q   <= bad;
      pn_q    <= page_addr_i[PAGE_SHIFT +: PN_W];
    end
    if (state_q == S_HEAD) begin
      page_q <= head_rd_page;
    end
  end

  always_comb begin
    state_d       = state_q;
    head_rd_en    = 1'b0;
    head_rd_cpu   = (opcode_i == OP_FREE) ? cpu_m : tgt;
    head_wr_en    = 1'b0;
    head_wr_cpu   = cpu_q;
    head_wr_page  = pn_q;
    head_wr_valid = 1'b1;
    link_rd_en    = 1'b0;
    link_wr_en    = 1'b0;
    link_wr_data  = {head_valid[cpu_q], head_rd_page};
    done          = 1'b0;
    done_addr     = '0;
    done_status   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          head_rd_en = 1'b1;
          state_d    = S_HEAD;
        end
      end
      S_HEAD: begin
        if (op_q == OP_FREE) begin
          done = 1'b1;
          if (bad_q) begin
            done_status = ST_BAD;
          end else begin
            link_wr_en = 1'b1;
            head_wr_en = 1'b1;
          end
          state_d = S_IDLE;
        end else if (!found_q) begin
          done        = 1'b1;
          done_status = ST_OOM;
          state_d     = S_IDLE;
        end else begin
          link_rd_en = 1'b1;
          state_d    = S_LINK;
        end
      end
      S_LINK: begin
        head_wr_en    = 1'b1;
        head_wr_cpu   = tgt_q;
        head_wr_page  = link_rd_data[PN_W-1:0];
        head_wr_valid = link_rd_data[PN_W];
        done          = 1'b1;
        done_addr     = ADDR_W'(page_q) << PAGE_SHIFT;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_addr_q   <= done_addr;
      out_status_q <= done_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_addr_q;
  assign status_o      = out_status_q;

  ppa_head_store #(
    .NUM_CPUS(NUM_CPUS),
    .CPU_W   (CPU_W),
    .PN_W    (PN_W)
  ) u_heads (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (head_rd_en),
    .rd_cpu_i  (head_rd_cpu),
    .rd_page_o (head_rd_page),
    .wr_en_i   (head_wr_en),
    .wr_cpu_i  (head_wr_cpu),
    .wr_page_i (head_wr_page),
    .wr_valid_i(head_wr_valid),
    .valid_o   (head_valid)
  );

  ppa_link_store #(
    .NUM_PAGES(NUM_PAGES),
    .PN_W     (PN_W)
  ) u_links (
    .clk_i    (clk_i),
    .rd_en_i  (link_rd_en),
    .rd_addr_i(head_rd_page),
    .rd_data_o(link_rd_data),
    .wr_en_i  (link_wr_en),
    .wr_addr_i(pn_q),
    .wr_data_i(link_wr_data)
  );

  // a finished word never lands on one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !out_valid_q) else $error("result word overwritten");

  // an accepted word always goes to the head read step next
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_HEAD) else $error("accept without head read");

  // the pop step only runs for an allocate that found a list
  a_link_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LINK |-> found_q && op_q == OP_ALLOC) else $error("bad pop");

  // a result word never carries the unused status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> status_o == ST_OK || status_o == ST_OOM || status_o == ST_BAD)
    else $error("illegal status");

endmodule
